>>> rtl/query_parameter_extract_decode_defines.svh
// Assertion macros for the query parameter extract/decode block.
// Expects clk and rst_n in the scope of each use.
`ifndef QUERY_PARAMETER_EXTRACT_DECODE_DEFINES_SVH
`define QUERY_PARAMETER_EXTRACT_DECODE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define QPED_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Same-cycle implication.
`define QPED_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define QPED_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/qped_pkg.sv
// Package for the query parameter extract/decode block: phase and register
// codes, character constants, result type and the hex pair decode function.
// No dependencies.
package qped_pkg;

    typedef enum logic [1:0] {
        PH_NAME  = 2'd0,
        PH_SKIP  = 2'd1,
        PH_VALUE = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        REG_NAME_LENGTH = 2'd0,
        REG_NAME_LOW    = 2'd1,
        REG_NAME_HIGH   = 2'd2
    } cfg_reg_t;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_MINUS   = 8'h2D;

    typedef struct packed {
        logic [7:0] value_byte;
        logic       value_valid;
        logic       done_res;
        logic       found;
    } result_t;

    // {is_hex, nibble}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] plain(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

    // Two bytes after a percent sign, decoded as a base-16 number would be
    // parsed: leading blank or sign allowed, parsing stops at the first non-hex.
    function automatic logic [7:0] strtol_pair(input logic [7:0] a, input logic [7:0] b);
        logic [4:0] ha;
        logic [4:0] hb;
        logic [7:0] r;
        ha = hex_val(a);
        hb = hex_val(b);
        r  = 8'd0;
        if (ha[4])
            r = hb[4] ? {ha[3:0], hb[3:0]} : {4'd0, ha[3:0]};
        else if (!hb[4])
            r = 8'd0;
        else if (is_blank(a) || a == CH_PLUS)
            r = {4'd0, hb[3:0]};
        else if (a == CH_MINUS)
            r = 8'd0 - {4'd0, hb[3:0]};
        return r;
    endfunction

endpackage

>>> rtl/query_parameter_extract_decode.sv
// Query parameter extract and percent decode, top level.
// Depends on qped_pkg and query_parameter_extract_decode_defines.svh.
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+-------------------------------------------
//  query    | query_valid  | query_stall  | query_byte, is_last
//  result   | result_valid | result_stall | value_byte, value_valid, done_res, found
//  config   | wr_en        | (none)       | wr_index, wr_data
//
// One query byte per cycle while query_stall is low. Each accepted request is decoded
// in the cycle it is taken and its results, up to two, land in a three-entry result queue.
// query_stall is raised from a register while two or more results are queued, so
// a two-result request (short percent at end of value) stalls the request after it.
// Reset clears the name registers, the parse state and the result queue.
// No combinational path runs from result_stall to query_stall.
`include "query_parameter_extract_decode_defines.svh"

module query_parameter_extract_decode #(
    parameter int MAX_NAME_BYTES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // query channel
    input  logic        query_valid,
    output logic        query_stall,
    input  logic [7:0]  query_byte,
    input  logic        is_last,
    // result channel
    output logic        result_valid,
    input  logic        result_stall,
    output logic [7:0]  value_byte,
    output logic        value_valid,
    output logic        done_res,
    output logic        found,
    // configuration writes
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [63:0] wr_data
);
    import qped_pkg::*;

    localparam logic [4:0] MAX_LEN = 5'(MAX_NAME_BYTES);

    // configuration registers
    logic [4:0]   name_length_reg;
    logic [63:0]  name_low_reg;
    logic [63:0]  name_high_reg;

    // parse state
    phase_t       phase_reg, phase_next;
    logic [4:0]   name_position_reg, name_position_next;
    logic         name_mismatch_reg, name_mismatch_next;
    logic [1:0]   held_count_reg, held_count_next;
    logic [7:0]   held_digit_reg, held_digit_next;

    // result queue, head at slot 0
    result_t      queue_reg [3];
    result_t      queue_next [3];
    logic [1:0]   count_reg, count_next;

    logic         accept;
    logic         pop;
    logic [4:0]   eff_len;
    logic [127:0] name_all;
    logic [7:0]   cur_name_byte;
    result_t      res0, res1;
    logic [1:0]   res_n;

    assign accept       = query_valid && !query_stall;
    assign query_stall  = count_reg[1];
    assign result_valid = (count_reg != 2'd0);
    assign pop          = result_valid && !result_stall;

    assign value_byte  = queue_reg[0].value_byte;
    assign value_valid = queue_reg[0].value_valid;
    assign done_res    = queue_reg[0].done_res;
    assign found       = queue_reg[0].found;

    // lengths above the supported maximum saturate
    assign eff_len       = (name_length_reg > MAX_LEN) ? MAX_LEN : name_length_reg;
    assign name_all      = {name_high_reg, name_low_reg};
    assign cur_name_byte = name_all[{name_position_reg[3:0], 3'b000} +: 8];

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_length_reg <= '0;
            name_low_reg    <= '0;
            name_high_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_NAME_LENGTH: name_length_reg <= wr_data[4:0];
                REG_NAME_LOW:    name_low_reg    <= wr_data;
                REG_NAME_HIGH:   name_high_reg   <= wr_data;
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // per-byte parse: next state and up to two results
    // ------------------------------------------------------------------
    always_comb
    begin
        logic b_amp;
        logic match_after;
        logic hit;
        b_amp       = (query_byte == CH_AMP);
        match_after = 1'b0;
        hit         = 1'b0;

        phase_next         = phase_reg;
        name_position_next = name_position_reg;
        name_mismatch_next = name_mismatch_reg;
        held_count_next    = held_count_reg;
        held_digit_next    = held_digit_reg;

        res0  = '0;
        res1  = '0;
        res_n = 2'd0;

        unique case (phase_reg)
            PH_NAME:
            begin
                if (b_amp)
                begin
                    if (!name_mismatch_reg && name_position_reg == eff_len)
                        phase_next = PH_DONE;
                    name_position_next = '0;
                    name_mismatch_next = 1'b0;
                end
                else if (query_byte == CH_EQUAL)
                begin
                    phase_next = (!name_mismatch_reg && name_position_reg == eff_len)
                                 ? PH_VALUE : PH_SKIP;
                    name_position_next = '0;
                    name_mismatch_next = 1'b0;
                end
                else
                begin
                    if (!name_mismatch_reg)
                    begin
                        if (name_position_reg < eff_len && cur_name_byte == query_byte)
                            name_position_next = name_position_reg + 5'd1;
                        else
                            name_mismatch_next = 1'b1;
                    end
                    match_after = !name_mismatch_next && (name_position_next == eff_len);
                    hit = is_last && match_after;
                end
            end
            PH_SKIP:
            begin
                if (b_amp)
                begin
                    phase_next         = PH_NAME;
                    name_position_next = '0;
                    name_mismatch_next = 1'b0;
                end
            end
            PH_VALUE:
            begin
                res0.value_valid = 1'b1;
                res1.value_valid = 1'b1;
                if (b_amp)
                begin
                    // flush any held percent sequence literally
                    phase_next       = PH_DONE;
                    held_count_next  = 2'd0;
                    held_digit_next  = 8'd0;
                    res0.value_byte  = CH_PERCENT;
                    res1.value_byte  = plain(held_digit_reg);
                    res_n            = held_count_reg;
                end
                else
                begin
                    unique case (held_count_reg)
                        2'd0:
                        begin
                            if (query_byte == CH_PERCENT)
                            begin
                                held_count_next = 2'd1;
                                res0.value_byte = CH_PERCENT;
                                res_n           = is_last ? 2'd1 : 2'd0;
                            end
                            else
                            begin
                                res0.value_byte = plain(query_byte);
                                res_n           = 2'd1;
                            end
                        end
                        2'd1:
                        begin
                            held_digit_next = query_byte;
                            held_count_next = 2'd2;
                            // short percent at end of query
                            res0.value_byte = CH_PERCENT;
                            res1.value_byte = plain(query_byte);
                            res_n           = is_last ? 2'd2 : 2'd0;
                        end
                        default:
                        begin
                            held_count_next = 2'd0;
                            held_digit_next = 8'd0;
                            res0.value_byte = strtol_pair(held_digit_reg, query_byte);
                            res_n           = 2'd1;
                        end
                    endcase
                end
            end
            PH_DONE:
            begin
            end
        endcase

        if (is_last)
        begin
            if (phase_next == PH_VALUE || phase_next == PH_DONE)
                hit = 1'b1;
            if (res_n == 2'd0)
            begin
                res0  = '0;
                res_n = 2'd1;
            end
            if (res_n == 2'd1)
            begin
                res0.done_res = 1'b1;
                res0.found    = hit;
            end
            else
            begin
                res1.done_res = 1'b1;
                res1.found    = hit;
            end
            phase_next         = PH_NAME;
            name_position_next = '0;
            name_mismatch_next = 1'b0;
            held_count_next    = 2'd0;
            held_digit_next    = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_NAME;
            name_position_reg <= '0;
            name_mismatch_reg <= 1'b0;
            held_count_reg    <= '0;
            held_digit_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            name_position_reg <= name_position_next;
            name_mismatch_reg <= name_mismatch_next;
            held_count_reg    <= held_count_next;
            held_digit_reg    <= held_digit_next;
        end
    end

    // ------------------------------------------------------------------
    // result queue: pop shifts toward slot 0, pushes land behind survivors
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [1:0] base;
        logic [1:0] push_n;
        base   = count_reg - {1'b0, pop};
        push_n = accept ? res_n : 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            queue_next[i] = queue_reg[i];
            if (pop && i < 2)
                queue_next[i] = queue_reg[i + 1];
            if (push_n != 2'd0 && base == 2'(i))
                queue_next[i] = res0;
            if (push_n == 2'd2 && (base + 2'd1) == 2'(i))
                queue_next[i] = res1;
        end
        count_next = base + push_n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        queue_reg <= queue_next;
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `QPED_ASSERT_IMPLIES(a_held_only_in_value, held_count_reg != 2'd0, phase_reg == PH_VALUE, "percent held outside value phase")
    `QPED_ASSERT_ALWAYS(a_position_bounded, name_position_reg <= eff_len, "name position past name length")
    `QPED_ASSERT_NEXT(a_last_restarts, accept && is_last, phase_reg == PH_NAME && held_count_reg == 2'd0 && !name_mismatch_reg, "parse state not restarted after last byte")
    `QPED_ASSERT_IMPLIES(a_found_with_done, result_valid && found, done_res, "found set without done")

endmodule

>>> sim/query_parameter_extract_decode_tb.sv
// Self-checking testbench for query_parameter_extract_decode: directed and
// random query strings, checked against a built-in decode of each request.
// Depends on qped_pkg and the query_parameter_extract_decode RTL.
module query_parameter_extract_decode_tb;

    import qped_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RANDOM_REQUESTS = 950;
    localparam int QUERIES_PER_SET = 10;
    localparam int HOLD_CYCLES     = 120;
    localparam int SETTLE_CYCLES   = 6;
    localparam int CYCLE_LIMIT     = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        query_valid = 1'b0;
    logic        query_stall;
    logic [7:0]  query_byte = 8'h00;
    logic        is_last = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [7:0]  value_byte;
    logic        value_valid;
    logic        done_res;
    logic        found;
    logic        wr_en = 1'b0;
    logic [1:0]  wr_index = 2'd0;
    logic [63:0] wr_data = 64'd0;

    query_parameter_extract_decode dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_stall  (query_stall),
        .query_byte   (query_byte),
        .is_last      (is_last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .value_byte   (value_byte),
        .value_valid  (value_valid),
        .done_res     (done_res),
        .found        (found),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    // ------------------------------------------------------------------
    // Decoder shadow: name registers and parse state, updated as each
    // request is accepted.
    // ------------------------------------------------------------------
    logic [4:0]  cfg_name_len = 5'd0;
    logic [63:0] cfg_name_low = 64'd0;
    logic [63:0] cfg_name_high = 64'd0;

    phase_t      parse_phase = PH_NAME;
    logic [4:0]  match_pos = 5'd0;
    logic        match_broken = 1'b0;
    logic [1:0]  pct_count = 2'd0;
    logic [7:0]  pct_digit = 8'd0;

    result_t     step_out[$];      // results of the request being decoded
    result_t     decoded_due[$];   // results not yet seen on the output
    logic [7:0]  query_text[$];    // query string about to be sent

    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned random_sent = 0;

    // Idling control shared by both sides.
    bit          steady = 1'b0;    // no random idling while set
    bit          hold_pending = 1'b0;
    logic        result_hold = 1'b0;

    string       name_chars = "abcdefghijklmnopqrstuvwxyz0123456789_.+%-";
    string       hex_chars  = "0123456789abcdefABCDEF";

    // Name length register saturates at the name buffer size.
    function automatic logic [4:0] name_len_eff();
        return (cfg_name_len > 5'd16) ? 5'd16 : cfg_name_len;
    endfunction

    function automatic logic [7:0] name_char(input logic [4:0] i);
        return (i < 5'd8) ? cfg_name_low[i[2:0]*8 +: 8] : cfg_name_high[i[2:0]*8 +: 8];
    endfunction

    function automatic logic name_hit();
        return !match_broken && (match_pos == name_len_eff());
    endfunction

    function automatic void restart_name();
        match_pos    = 5'd0;
        match_broken = 1'b0;
    endfunction

    // Hex digit value, or -1 for anything else.
    function automatic int nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c) - int'("0");
        if (c >= "a" && c <= "f")
            return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic logic blank_char(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] space_for_plus(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

    // Two bytes after a '%', read the way a base-16 parse would: optional
    // blank or sign first, parse stops at the first non-hex byte.
    function automatic logic [7:0] pct_pair_value(input logic [7:0] a, input logic [7:0] b);
        int na;
        int nb;
        na = nibble_of(a);
        nb = nibble_of(b);
        if (na >= 0)
            return (nb >= 0) ? 8'(na * 16 + nb) : 8'(na);
        if (nb < 0)
            return 8'h00;
        if (blank_char(a) || a == CH_PLUS)
            return 8'(nb);
        if (a == CH_MINUS)
            return 8'(256 - nb);
        return 8'h00;
    endfunction

    function automatic void emit_value(input logic [7:0] v);
        result_t r;
        r             = '0;
        r.value_byte  = v;
        r.value_valid = 1'b1;
        step_out.push_back(r);
    endfunction

    // A '%' cut short by the end of the value goes out literally, followed
    // by the byte held after it.
    function automatic void release_percent();
        if (pct_count >= 2'd1)
            emit_value(CH_PERCENT);
        if (pct_count >= 2'd2)
            emit_value(space_for_plus(pct_digit));
        pct_count = 2'd0;
        pct_digit = 8'd0;
    endfunction

    // Decode one accepted request and queue the results it must produce.
    function automatic void decode_query_byte(input logic [7:0] b, input logic last);
        logic    hit;
        result_t closing;
        hit = 1'b0;
        step_out.delete();
        case (parse_phase)
            PH_NAME:
            begin
                if (b == CH_AMP)
                begin
                    if (name_hit())
                        parse_phase = PH_DONE;
                    restart_name();
                end
                else if (b == CH_EQUAL)
                begin
                    parse_phase = name_hit() ? PH_VALUE : PH_SKIP;
                    restart_name();
                end
                else
                begin
                    if (!match_broken)
                    begin
                        if (match_pos < name_len_eff() && name_char(match_pos) == b)
                            match_pos = match_pos + 5'd1;
                        else
                            match_broken = 1'b1;
                    end
                    // bare entry ending the query
                    if (last && name_hit())
                        hit = 1'b1;
                end
            end
            PH_SKIP:
            begin
                if (b == CH_AMP)
                begin
                    parse_phase = PH_NAME;
                    restart_name();
                end
            end
            PH_VALUE:
            begin
                if (b == CH_AMP)
                begin
                    release_percent();
                    parse_phase = PH_DONE;
                end
                else if (pct_count == 2'd0)
                begin
                    if (b == CH_PERCENT)
                        pct_count = 2'd1;
                    else
                        emit_value(space_for_plus(b));
                end
                else if (pct_count == 2'd1)
                begin
                    pct_digit = b;
                    pct_count = 2'd2;
                end
                else
                begin
                    emit_value(pct_pair_value(pct_digit, b));
                    pct_count = 2'd0;
                    pct_digit = 8'd0;
                end
                if (last)
                    release_percent();
            end
            default:
                ;
        endcase

        if (last)
        begin
            if (parse_phase == PH_VALUE || parse_phase == PH_DONE)
                hit = 1'b1;
            if (step_out.size() == 0)
                step_out.push_back('0);
            // done rides on the last result of this request
            closing          = step_out.pop_back();
            closing.done_res = 1'b1;
            closing.found    = hit;
            step_out.push_back(closing);
            parse_phase = PH_NAME;
            restart_name();
            pct_count = 2'd0;
            pct_digit = 8'd0;
        end

        foreach (step_out[i])
            decoded_due.push_back(step_out[i]);
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, cycle limit
    // ------------------------------------------------------------------
    initial
    begin
        forever
            #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("%0t: timeout after %0d cycles", $time, cycle_count);
                $display("query_parameter_extract_decode verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stall, plus one long hold-off on request so that
    // the result queue fills and the block stalls its query input.
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            wait (hold_pending);
            @(posedge clk);
            result_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            result_hold <= 1'b0;
            hold_pending = 1'b0;
        end
    end

    task automatic check_result();
        result_t want;
        if (decoded_due.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result value_byte %02h value_valid %0b done %0b found %0b",
                     $time, value_byte, value_valid, done_res, found);
            return;
        end
        want = decoded_due.pop_front();
        if (value_byte !== want.value_byte)
        begin
            mismatches++;
            $display("%0t: value_byte expected %02h actual %02h",
                     $time, want.value_byte, value_byte);
        end
        if (value_valid !== want.value_valid)
        begin
            mismatches++;
            $display("%0t: value_valid expected %0b actual %0b",
                     $time, want.value_valid, value_valid);
        end
        if (done_res !== want.done_res)
        begin
            mismatches++;
            $display("%0t: done_res expected %0b actual %0b", $time, want.done_res, done_res);
        end
        if (found !== want.found)
        begin
            mismatches++;
            $display("%0t: found expected %0b actual %0b", $time, want.found, found);
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            // stall sampled here is the one driven at the previous edge
            if (rst_n && result_valid === 1'b1 && result_stall === 1'b0)
                check_result();
            result_stall <= result_hold || (!steady && $urandom_range(0, 99) < 34);
        end
    end

    // ------------------------------------------------------------------
    // Query side
    // ------------------------------------------------------------------

    // Offer one request and wait until the block takes it.
    task automatic send_request(input logic [7:0] b, input logic last);
        while (!steady && $urandom_range(0, 99) < 34)
        begin
            query_valid <= 1'b0;
            @(posedge clk);
        end
        query_valid <= 1'b1;
        query_byte  <= b;
        is_last     <= last;
        @(posedge clk);
        while (query_stall !== 1'b0)
            @(posedge clk);
        decode_query_byte(b, last);
    endtask

    task automatic send_query();
        foreach (query_text[i])
            send_request(query_text[i], i == query_text.size() - 1);
    endtask

    task automatic load_text(input string s);
        query_text.delete();
        for (int i = 0; i < s.len(); i++)
            query_text.push_back(s[i]);
    endtask

    // Drop valid right after the last acceptance, drain every result, then
    // let the block settle before anything is reconfigured.
    task automatic quiesce();
        query_valid <= 1'b0;
        while (decoded_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] d);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= d;
        case (idx)
            REG_NAME_LENGTH: cfg_name_len  = d[4:0];
            REG_NAME_LOW:    cfg_name_low  = d;
            REG_NAME_HIGH:   cfg_name_high = d;
            default:         ;
        endcase
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] pick_name_char();
        return name_chars[$urandom_range(0, name_chars.len() - 1)];
    endfunction

    // Value bytes lean toward the interesting ones: hex digits, '%', '+',
    // sign, blanks.
    function automatic logic [7:0] pick_value_char();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30)
            return hex_chars[$urandom_range(0, hex_chars.len() - 1)];
        if (sel < 45)
            return CH_PERCENT;
        if (sel < 52)
            return CH_PLUS;
        if (sel < 58)
            return CH_MINUS;
        if (sel < 64)
            return ($urandom_range(0, 1) == 0) ? CH_SPACE : 8'($urandom_range(9, 13));
        if (sel < 67)
            return CH_AMP;
        if (sel < 70)
            return CH_EQUAL;
        return 8'($urandom_range(0, 255));
    endfunction

    // One query string: mostly well-formed entries built around the current
    // name, some near misses, some pure noise.
    task automatic make_query();
        int         entries;
        int         style;
        logic [7:0] nm[$];
        int         pos;
        query_text.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 12))
                query_text.push_back(8'($urandom_range(0, 255)));
            return;
        end
        entries = $urandom_range(1, 4);
        for (int e = 0; e < entries; e++)
        begin
            if (e > 0)
                query_text.push_back(CH_AMP);
            nm.delete();
            style = $urandom_range(0, 99);
            if (style < 70)
            begin
                for (int i = 0; i < name_len_eff(); i++)
                    nm.push_back(name_char(5'(i)));
            end
            if (style >= 50 && style < 70)
            begin
                // near miss: one byte off, one short or one long
                case ($urandom_range(0, 2))
                    0:
                    begin
                        if (nm.size() > 0)
                        begin
                            pos = $urandom_range(0, nm.size() - 1);
                            nm[pos] = nm[pos] ^ 8'($urandom_range(1, 255));
                        end
                    end
                    1:
                    begin
                        if (nm.size() > 0)
                            void'(nm.pop_back());
                    end
                    default:
                        nm.push_back(pick_name_char());
                endcase
            end
            else if (style >= 70)
            begin
                repeat ($urandom_range(0, 5))
                    nm.push_back(pick_name_char());
            end
            foreach (nm[i])
                query_text.push_back(nm[i]);
            if ($urandom_range(0, 9) < 8)
            begin
                query_text.push_back(CH_EQUAL);
                repeat ($urandom_range(0, 10))
                    query_text.push_back(pick_value_char());
            end
        end
        if ($urandom_range(0, 99) < 15)
            query_text.push_back(CH_AMP);
        if (query_text.size() == 0)
            query_text.push_back(pick_name_char());
    endtask

    // Name registers for one random phase; the first few are the extremes.
    task automatic apply_setting(input int s);
        logic [63:0] len_word;
        logic [63:0] lo;
        logic [63:0] hi;
        for (int i = 0; i < 8; i++)
        begin
            lo[i*8 +: 8] = pick_name_char();
            hi[i*8 +: 8] = pick_name_char();
        end
        case (s)
            0: len_word = 64'd16;
            // saturates to 16; upper bits of the write are don't-care
            1: len_word = {$urandom, $urandom} | 64'h1F;
            2: len_word = 64'd0;
            3:
            begin
                len_word = 64'($urandom_range(1, 16));
                lo       = {$urandom, $urandom};
                hi       = {$urandom, $urandom};
            end
            default: len_word = 64'($urandom_range(0, 20));
        endcase
        write_reg(REG_NAME_LENGTH, len_word);
        write_reg(REG_NAME_LOW, lo);
        write_reg(REG_NAME_HIGH, hi);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset name is empty, so "=..." matches; the value ends with a '%' and
    // one held byte, so the final request produces two results.
    task automatic test_empty_name_short_percent();
        load_text("=+%4");
        send_query();
        quiesce();
    endtask

    // Entry with no '=' that matches, followed by a trailing empty entry;
    // first entry carries the lowest byte.
    task automatic test_bare_entry_trailing_amp();
        write_reg(REG_NAME_LENGTH, 64'd1);
        write_reg(REG_NAME_LOW, 64'h6B);    // "k"
        load_text("x&k&");
        query_text[0] = 8'h00;
        send_query();
        quiesce();
    endtask

    // Hex pairs in both cases, minus sign, hex followed by non-hex, the
    // highest byte, and a lone '%' at the end of the query.
    task automatic test_percent_decode();
        load_text("k=%fF%-A%0zX%");
        query_text[11] = 8'hFF;
        send_query();
        quiesce();
    endtask

    task automatic test_random_queries();
        int query_count;
        int setting;
        query_count = 0;
        setting     = 0;
        while (random_sent < RANDOM_REQUESTS)
        begin
            if (query_count % QUERIES_PER_SET == 0)
            begin
                quiesce();
                apply_setting(setting);
                // first phase without idling, then one long result hold-off
                steady = (setting == 0);
                if (setting == 1)
                    hold_pending = 1'b1;
                setting++;
            end
            make_query();
            send_query();
            random_sent += query_text.size();
            query_count++;
        end
        steady = 1'b0;
        quiesce();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_name_short_percent();
        test_bare_entry_trailing_amp();
        test_percent_decode();
        test_random_queries();

        while (hold_pending)
            @(posedge clk);
        quiesce();

        if (mismatches == 0)
            $display("query_parameter_extract_decode verification clean");
        else
            $display("query_parameter_extract_decode verification failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/qped_pkg.sv
rtl/query_parameter_extract_decode.sv
sim/query_parameter_extract_decode_tb.sv
